### hw/rtl/assert_macros.svh
// Assertion macros shared by the servo bus command link RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define SBCL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sbcl assertion failed");
// Antecedent in a cycle implies consequent in the following cycle.
`define SBCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbcl assertion failed");
`else
`define SBCL_ASSERT(label, clk, rst_n, prop)
`define SBCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/sbcl_pkg.sv
// Types and constants for the servo bus command link.
package sbcl_pkg;

    localparam int unsigned TDATA_W = 32;

    localparam logic [7:0] HDR_BYTE       = 8'h55;
    localparam logic [7:0] LEN_READ       = 8'h03;
    localparam logic [7:0] LEN_WRITE      = 8'h07;
    localparam logic [7:0] CMD_READ_TEMP  = 8'h1A;
    localparam logic [7:0] CMD_READ_POS   = 8'h1C;
    localparam logic [7:0] CMD_WRITE_POS  = 8'h01;
    localparam logic [7:0] TEMP_LIMIT     = 8'd100;
    localparam logic [7:0] POS_HI_LIMIT   = 8'd4;
    localparam logic [15:0] MOVE_TIME_RST = 16'h0032;

    // Packet lengths on the wire, header and checksum included
    localparam logic [3:0] PKT_LEN_READ  = 4'd6;
    localparam logic [3:0] PKT_LEN_WRITE = 4'd10;

    // Reply lengths in bytes
    localparam logic [3:0] REPLY_LEN_TEMP = 4'd7;
    localparam logic [3:0] REPLY_LEN_POS  = 4'd8;

    typedef enum logic [1:0] {
        KIND_TEMP  = 2'd0,
        KIND_POS   = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_RX    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_TX  = 2'd0,
        RES_OK  = 2'd1,
        RES_REJ = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_TEMP = 2'd1,
        PEND_POS  = 2'd2
    } pend_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       first;
        logic       last;
    } frame_t;

    typedef struct packed {
        logic       emit;
        logic       ok;
        logic [7:0] servo;
        logic       is_pos;
        logic [9:0] value;
    } reply_t;

endpackage

### hw/rtl/sbcl_framer.sv
// Command packet framer: byte counter, byte select and checksum.
`include "assert_macros.svh"

module sbcl_framer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sbcl_pkg::kind_t     kind,
    input  logic [7:0]          bus_id,
    input  logic [9:0]          angle,
    input  logic [15:0]         move_time,
    output sbcl_pkg::frame_t    frame
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [3:0] pkt_len;
    logic [7:0] len_byte;
    logic [7:0] cmd_byte;
    logic [7:0] angle_lo;
    logic [7:0] angle_hi;
    logic [7:0] sum;
    logic       is_write;

    assign is_write = (kind == sbcl_pkg::KIND_WRITE);
    assign pkt_len  = is_write ? sbcl_pkg::PKT_LEN_WRITE : sbcl_pkg::PKT_LEN_READ;
    assign len_byte = is_write ? sbcl_pkg::LEN_WRITE : sbcl_pkg::LEN_READ;
    assign angle_lo = angle[7:0];
    assign angle_hi = {6'd0, angle[9:8]};

    always_comb
    begin
        case (kind)
            sbcl_pkg::KIND_TEMP:  cmd_byte = sbcl_pkg::CMD_READ_TEMP;
            sbcl_pkg::KIND_POS:   cmd_byte = sbcl_pkg::CMD_READ_POS;
            sbcl_pkg::KIND_WRITE: cmd_byte = sbcl_pkg::CMD_WRITE_POS;
            default:              cmd_byte = sbcl_pkg::CMD_WRITE_POS;
        endcase
    end

    // byte sum from the id up to the last parameter
    always_comb
    begin
        sum = bus_id + len_byte + cmd_byte;
        if (is_write)
        begin
            sum = sum + angle_lo + angle_hi + move_time[7:0] + move_time[15:8];
        end
    end

    always_comb
    begin
        frame.first = (idx_reg == 4'd0);
        frame.last  = (idx_reg == pkt_len - 4'd1);
        case (idx_reg)
            4'd0:    frame.tx_byte = sbcl_pkg::HDR_BYTE;
            4'd1:    frame.tx_byte = sbcl_pkg::HDR_BYTE;
            4'd2:    frame.tx_byte = bus_id;
            4'd3:    frame.tx_byte = len_byte;
            4'd4:    frame.tx_byte = cmd_byte;
            4'd5:    frame.tx_byte = is_write ? angle_lo : ~sum;
            4'd6:    frame.tx_byte = angle_hi;
            4'd7:    frame.tx_byte = move_time[7:0];
            4'd8:    frame.tx_byte = move_time[15:8];
            default: frame.tx_byte = ~sum;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (step)
        begin
            idx_next = frame.last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 4'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    `SBCL_ASSERT(a_idx_in_range, clk, rst_n, idx_reg < sbcl_pkg::PKT_LEN_WRITE)
    `SBCL_ASSERT_NEXT(a_idx_wraps, clk, rst_n, step && frame.last, idx_reg == 4'd0)

endmodule

### hw/rtl/sbcl_reply_checker.sv
// Reply collector and checker with the pending request state.
`include "assert_macros.svh"

module sbcl_reply_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start_read,
    input  sbcl_pkg::kind_t     read_kind,
    input  logic [7:0]          read_servo,
    input  logic                rx_step,
    input  logic [7:0]          rx_byte,
    output sbcl_pkg::reply_t    reply
);

    sbcl_pkg::pend_t pend_reg;
    sbcl_pkg::pend_t pend_next;
    logic [7:0]      servo_reg;
    logic [7:0]      servo_next;
    logic [3:0]      count_reg;
    logic [3:0]      count_next;
    // the final reply byte is never checked, so only the first seven are kept
    logic [7:0]      bytes_reg [7];
    logic            is_pos;
    logic [3:0]      need;
    logic            hdr_ok;
    logic            ok;
    logic            store;

    assign is_pos = (pend_reg == sbcl_pkg::PEND_POS);
    assign need   = is_pos ? sbcl_pkg::REPLY_LEN_POS : sbcl_pkg::REPLY_LEN_TEMP;
    assign hdr_ok = (bytes_reg[0] == sbcl_pkg::HDR_BYTE)
                 && (bytes_reg[1] == sbcl_pkg::HDR_BYTE)
                 && (bytes_reg[2] == servo_reg);

    always_comb
    begin
        if (is_pos)
        begin
            ok = hdr_ok && (bytes_reg[4] == sbcl_pkg::CMD_READ_POS)
                        && (bytes_reg[6] < sbcl_pkg::POS_HI_LIMIT);
        end
        else
        begin
            ok = hdr_ok && (bytes_reg[4] == sbcl_pkg::CMD_READ_TEMP)
                        && (bytes_reg[5] < sbcl_pkg::TEMP_LIMIT);
        end
        reply.emit   = (pend_reg != sbcl_pkg::PEND_NONE) && (count_reg + 4'd1 == need);
        reply.ok     = ok;
        reply.servo  = servo_reg;
        reply.is_pos = is_pos;
        if (!ok)
        begin
            reply.value = 10'd0;
        end
        else if (is_pos)
        begin
            reply.value = {bytes_reg[6][1:0], bytes_reg[5]};
        end
        else
        begin
            reply.value = {2'd0, bytes_reg[5]};
        end
    end

    assign store = rx_step && (pend_reg != sbcl_pkg::PEND_NONE) && !reply.emit;

    always_comb
    begin
        pend_next  = pend_reg;
        servo_next = servo_reg;
        count_next = count_reg;
        if (start_read)
        begin
            // a new read drops any reply still being collected
            servo_next = read_servo;
            pend_next  = (read_kind == sbcl_pkg::KIND_TEMP) ? sbcl_pkg::PEND_TEMP
                                                            : sbcl_pkg::PEND_POS;
            count_next = 4'd0;
        end
        else if (rx_step && reply.emit)
        begin
            pend_next  = sbcl_pkg::PEND_NONE;
            count_next = 4'd0;
        end
        else if (store)
        begin
            count_next = count_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= sbcl_pkg::PEND_NONE;
            servo_reg <= 8'd0;
            count_reg <= 4'd0;
        end
        else
        begin
            pend_reg  <= pend_next;
            servo_reg <= servo_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            bytes_reg[count_reg[2:0]] <= rx_byte;
        end
    end

    `SBCL_ASSERT(a_count_bound, clk, rst_n, count_reg < sbcl_pkg::REPLY_LEN_POS)
    `SBCL_ASSERT(a_idle_count, clk, rst_n, (pend_reg != sbcl_pkg::PEND_NONE) || (count_reg == 4'd0))

endmodule

### hw/rtl/servo_bus_command_link_unit.sv
// Top level of the servo bus command link: job register, output register, wiring.
//
//  channel   dir  fields (low bit up)                                    accept
//  s_*       in   tuser: kind; tdata: bus_id, angle, rx_byte             s_tvalid & s_tready
//  m_*       out  tuser: result_kind; tlast: last_byte;
//                 tdata: tx_byte, reply_servo, reply_is_position, value  m_tvalid & m_tready
//  move_time in   move_time_wdata, written when move_time_we is high     move_time_we
//
// Read requests send 6 packet bytes, position writes 10 (one packet byte per cycle
// while m_tready does not stall the single output register). A transaction
// waits in the job register while its bytes drain; s_tready rises in the
// cycle its last packet byte is loaded or its received byte retires. An
// m_tready stall holds the output register and any job that needs it. Reset
// clears control state and sets move_time to 50.
`include "assert_macros.svh"

module servo_bus_command_link_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bus_id[7:0], angle[17:8], rx_byte[25:18], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], reply_servo[15:8], reply_is_position[16],
                                   // reply_value[26:17], zero pad
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    output logic        m_tlast,   // last_byte
    input  logic        move_time_we,
    input  logic [15:0] move_time_wdata
);

    logic            job_valid_reg;
    logic            job_valid_next;
    sbcl_pkg::kind_t job_kind_reg;
    logic [7:0]      job_id_reg;
    logic [9:0]      job_angle_reg;
    logic [7:0]      job_rx_reg;
    logic [15:0]     move_time_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [1:0]      out_kind_reg;
    logic [7:0]      out_tx_reg;
    logic            out_last_reg;
    logic [7:0]      out_servo_reg;
    logic            out_pos_reg;
    logic [9:0]      out_value_reg;

    sbcl_pkg::frame_t frame;
    sbcl_pkg::reply_t reply;

    logic in_accept;
    logic out_load;
    logic is_req;
    logic fire_tx;
    logic fire_rx;
    logic job_done;
    logic load;
    logic start_read;

    assign in_accept = s_tvalid && s_tready;
    assign out_load  = !out_valid_reg || m_tready;
    assign is_req    = (job_kind_reg != sbcl_pkg::KIND_RX);
    assign fire_tx   = job_valid_reg && is_req && out_load;
    // bytes that produce no result retire without the output register
    assign fire_rx   = job_valid_reg && !is_req && (!reply.emit || out_load);
    assign job_done  = fire_rx || (fire_tx && frame.last);
    assign load      = fire_tx || (fire_rx && reply.emit);
    assign s_tready  = !job_valid_reg || job_done;
    assign start_read = fire_tx && frame.first && (job_kind_reg != sbcl_pkg::KIND_WRITE);

    sbcl_framer u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire_tx),
        .kind      (job_kind_reg),
        .bus_id    (job_id_reg),
        .angle     (job_angle_reg),
        .move_time (move_time_reg),
        .frame     (frame)
    );

    sbcl_reply_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_read (start_read),
        .read_kind  (job_kind_reg),
        .read_servo (job_id_reg),
        .rx_step    (fire_rx),
        .rx_byte    (job_rx_reg),
        .reply      (reply)
    );

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (in_accept)
        begin
            job_valid_next = 1'b1;
        end
        else if (job_done)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            move_time_reg <= sbcl_pkg::MOVE_TIME_RST;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            if (move_time_we)
            begin
                move_time_reg <= move_time_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            job_kind_reg  <= sbcl_pkg::kind_t'(s_tuser);
            job_id_reg    <= s_tdata[7:0];
            job_angle_reg <= s_tdata[17:8];
            job_rx_reg    <= s_tdata[25:18];
        end
        if (load)
        begin
            if (fire_tx)
            begin
                out_kind_reg  <= sbcl_pkg::RES_TX;
                out_tx_reg    <= frame.tx_byte;
                out_last_reg  <= frame.last;
                out_servo_reg <= 8'd0;
                out_pos_reg   <= 1'b0;
                out_value_reg <= 10'd0;
            end
            else
            begin
                out_kind_reg  <= reply.ok ? sbcl_pkg::RES_OK : sbcl_pkg::RES_REJ;
                out_tx_reg    <= 8'd0;
                out_last_reg  <= 1'b0;
                out_servo_reg <= reply.servo;
                out_pos_reg   <= reply.is_pos;
                out_value_reg <= reply.value;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_value_reg, out_pos_reg, out_servo_reg, out_tx_reg};

    `SBCL_ASSERT_NEXT(a_req_blocks, clk, rst_n,
        in_accept && (s_tuser != sbcl_pkg::KIND_RX), !s_tready)
    `SBCL_ASSERT(a_last_only_tx, clk, rst_n,
        !(m_tvalid && m_tlast) || (m_tuser == sbcl_pkg::RES_TX))

endmodule
